[hw/rtl/hsd_pkg.sv]
package hsd_pkg;

  localparam int CW_W   = 63;  // codeword width
  localparam int LEN_W  = 6;   // code length / syndrome width
  localparam int DATA_W = 57;  // packed data bits
  localparam int CFG_AW = 3;   // APB byte address width
  localparam int CFG_DW = 32;

  // register word index taken from paddr[CFG_AW-1:2]
  localparam logic REG_CODE_LENGTH = 1'b0;

  // after masking
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CW_W-1:0]  word;
  } hsd_s1_t;

  // after syndrome
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] syn;
    logic [CW_W-1:0]  word;
  } hsd_s2_t;

  typedef struct packed {
    logic              error_found;
    logic [LEN_W-1:0]  error_position;
    logic              position_invalid;
    logic [CW_W-1:0]   corrected_codeword;
    logic [DATA_W-1:0] data_word;
    logic [LEN_W-1:0]  data_width;
  } hsd_res_t;

endpackage

[hw/rtl/hsd_cfg_regs.sv]
module hsd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hsd_pkg::CFG_AW-1:0] paddr,
  input  logic [hsd_pkg::CFG_DW-1:0] pwdata,
  output logic [hsd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic [hsd_pkg::LEN_W-1:0]  code_length
);
  import hsd_pkg::*;

  logic [LEN_W-1:0] code_length_r;
  logic             hit;
  logic             wr_en;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_AW-1:2] == REG_CODE_LENGTH);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= LEN_W'(7);
    end else if (wr_en) begin
      code_length_r <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = CFG_DW'(code_length_r);
    end
  end

  assign code_length = code_length_r;

endmodule

[hw/rtl/hsd_mask_stage.sv]
module hsd_mask_stage #(
  parameter int MAX_LEN = 63
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [hsd_pkg::CW_W-1:0]  word_i,
  input  logic [hsd_pkg::LEN_W-1:0] code_length_i,
  output logic                      valid_o,
  output hsd_pkg::hsd_s1_t          s1_o
);
  import hsd_pkg::*;

  logic             valid_r;
  hsd_s1_t          s1_r;
  hsd_s1_t          s1_nxt;
  logic [LEN_W-1:0] len;
  logic [CW_W:0]    bound;

  // clamp to the build-time limit, then clear positions above it
  assign len   = (code_length_i > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : code_length_i;
  assign bound = (CW_W+1)'(1) << len;

  always_comb begin
    s1_nxt.len  = len;
    s1_nxt.word = word_i & CW_W'(bound - (CW_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i && valid_i) begin
      s1_r <= s1_nxt;
    end
  end

  assign valid_o = valid_r;
  assign s1_o    = s1_r;

endmodule

[hw/rtl/hsd_syndrome_stage.sv]
module hsd_syndrome_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  logic             valid_i,
  input  hsd_pkg::hsd_s1_t s1_i,
  output logic             valid_o,
  output hsd_pkg::hsd_s2_t s2_o
);
  import hsd_pkg::*;

  // positions (bit index + 1) whose index has syndrome bit k set
  function automatic logic [CW_W-1:0] cover_mask(input int k);
    logic [CW_W-1:0] m;
    m = '0;
    for (int i = 0; i < CW_W; i++) begin
      m[i] = ((((i + 1) >> k) & 1) != 0);
    end
    return m;
  endfunction

  logic             valid_r;
  hsd_s2_t          s2_r;
  logic [LEN_W-1:0] syn;

  for (genvar k = 0; k < LEN_W; k++) begin : g_par
    localparam logic [CW_W-1:0] COVER = cover_mask(k);
    assign syn[k] = ^(s1_i.word & COVER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i && valid_i) begin
      s2_r.len  <= s1_i.len;
      s2_r.syn  <= syn;
      s2_r.word <= s1_i.word;
    end
  end

  assign valid_o = valid_r;
  assign s2_o    = s2_r;

endmodule

[hw/rtl/hsd_correct_stage.sv]
module hsd_correct_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  logic             valid_i,
  input  hsd_pkg::hsd_s2_t s2_i,
  output logic             valid_o,
  output hsd_pkg::hsd_res_t res_o
);
  import hsd_pkg::*;

  // codeword position (from 1) of data bit j
  function automatic int data_pos(input int j);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == j) begin
          pos = p;
        end
        cnt++;
      end
    end
    return pos;
  endfunction

  logic              valid_r;
  hsd_res_t          res_r;
  hsd_res_t          res_nxt;
  logic              invalid;
  logic              flip;
  logic [LEN_W-1:0]  sidx;
  logic [CW_W-1:0]   corr;
  logic [DATA_W-1:0] data;
  logic [LEN_W-1:0]  msb;

  assign invalid = s2_i.syn > s2_i.len;
  assign flip    = (s2_i.syn != '0) && !invalid;
  assign sidx    = s2_i.syn - LEN_W'(1);
  assign corr    = s2_i.word ^ (CW_W'(flip) << sidx);

  for (genvar j = 0; j < DATA_W; j++) begin : g_data
    localparam int POS = data_pos(j);
    assign data[j] = corr[POS-1];
  end

  // parity bits in use = floor(log2(len)) + 1
  always_comb begin
    msb = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (s2_i.len[b]) begin
        msb = LEN_W'(b);
      end
    end
  end

  always_comb begin
    res_nxt.error_found        = (s2_i.syn != '0);
    res_nxt.error_position     = s2_i.syn;
    res_nxt.position_invalid   = invalid;
    res_nxt.corrected_codeword = corr;
    res_nxt.data_word          = data;
    res_nxt.data_width         = (s2_i.len == '0) ? '0 : s2_i.len - msb - LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i && valid_i) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

[hw/rtl/hamming_sec_decoder.sv]
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready  | in_tdata: codeword
// out_    | master    | out_tvalid / out_tready| out_tdata: decode result
// cfg_    | APB slave | psel, penable, pready  | code_length at byte 0
//
// One transaction per cycle sustained while out_tready stays high; out_tvalid
// rises once a transaction has passed through the mask, syndrome and
// correction register stages.
// rst_n is synchronous, active low: clears the stage valids and sets
// code_length to 7. A stall on out_tready holds each full stage with no empty
// stage after it; an empty stage still loads, squeezing out bubbles under back-pressure.
module hamming_sec_decoder #(
  parameter int MAX_LEN = 63  // largest code length honoured, 3..63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // [62:0] codeword, [63] zero
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,
  // [0] error_found, [6:1] error_position, [7] position_invalid,
  // [70:8] corrected_codeword, [127:71] data_word, [133:128] data_width,
  // [135:134] zero
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [135:0]               out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hsd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hsd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hsd_pkg::*;

  logic [LEN_W-1:0] code_length;
  logic             v1;
  logic             v2;
  logic             v3;
  logic             rdy1;
  logic             rdy2;
  logic             rdy3;
  hsd_s1_t          s1;
  hsd_s2_t          s2;
  hsd_res_t         res;

  // a stage loads when it is empty or its contents move on this cycle
  assign rdy3      = !v3 || out_tready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_tready = rdy1;

  hsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .code_length (code_length)
  );

  // stage 1: clamp length, drop unused positions
  hsd_mask_stage #(
    .MAX_LEN (MAX_LEN)
  ) u_mask (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv_i         (rdy1),
    .valid_i       (in_tvalid),
    .word_i        (in_tdata[CW_W-1:0]),
    .code_length_i (code_length),
    .valid_o       (v1),
    .s1_o          (s1)
  );

  // stage 2: parity trees
  hsd_syndrome_stage u_syn (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_i   (rdy2),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v2),
    .s2_o    (s2)
  );

  // stage 3: range check, bit flip, data extraction; doubles as output register
  hsd_correct_stage u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_i   (rdy3),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (v3),
    .res_o   (res)
  );

  assign out_tvalid = v3;
  assign out_tdata  = {2'b00,
                       res.data_width,
                       res.data_word,
                       res.corrected_codeword,
                       res.position_invalid,
                       res.error_position,
                       res.error_found};

endmodule
